// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ffp_pkg.sv =====
package ffp_pkg;

    localparam int NUM_LEDS_DEF = 5;
    localparam int LANE_LIMIT   = 5;
    localparam int LEVEL_W      = 8;
    localparam int HOLD_W       = 16;
    localparam int SCALE_W      = 4;
    localparam int RND_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 8'd100;
    localparam logic [SCALE_W-1:0] OFF_SCALE_RST = 4'd5;
    localparam logic [LEVEL_W-1:0] PWM_COUNT_RST = 8'd255;

    // Initial off time of each LED, LED 4 first.
    localparam logic [LANE_LIMIT-1:0][HOLD_W-1:0] HOLD_RST = {
        16'd150, 16'd50, 16'd500, 16'd10, 16'd1000
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_LEVEL = 2'd0,
        REG_OFF_SCALE = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        CMD_PWM_TICK = 1'b0,
        CMD_UPDATE   = 1'b1
    } command_t;

    typedef logic [LEVEL_W-1:0] level_t;

endpackage

// ===== rtl/ffp_lane.sv =====
module ffp_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             update_en,
    input  logic [ffp_pkg::RND_W-1:0]        rnd,
    input  ffp_pkg::level_t                  max_level,
    input  logic [ffp_pkg::SCALE_W-1:0]      off_scale,
    output ffp_pkg::level_t                  level
);

    ffp_pkg::level_t                 level_reg,  level_next;
    logic [ffp_pkg::HOLD_W-1:0]      hold_reg,   hold_next;
    logic                            ramp_reg,   ramp_next;
    logic [ffp_pkg::HOLD_W-1:0]      hold_dec;
    ffp_pkg::level_t                 level_dec;
    logic [ffp_pkg::RND_W:0]         rnd_inc;
    logic [ffp_pkg::RND_W+ffp_pkg::SCALE_W:0] off_time;

    assign hold_dec  = hold_reg - 1'b1;
    assign level_dec = level_reg - 1'b1;
    assign rnd_inc   = {1'b0, rnd} + 1'b1;
    assign off_time  = rnd_inc * off_scale;

    always_comb begin
        level_next = level_reg;
        hold_next  = hold_reg;
        ramp_next  = ramp_reg;
        if (update_en) begin
            if (level_reg == max_level) begin
                // Fully on: hold, then start ramping down.
                hold_next = hold_dec;
                if (hold_dec == '0) begin
                    level_next = level_dec;
                    ramp_next  = 1'b0;
                end
            end else if (level_reg == '0) begin
                // Off: rest, then start ramping up with a fresh on time.
                hold_next = hold_dec;
                if (hold_dec == '0) begin
                    level_next = ffp_pkg::level_t'(1);
                    ramp_next  = 1'b1;
                    hold_next  = ffp_pkg::HOLD_W'(rnd_inc);
                end
            end else if (ramp_reg) begin
                level_next = level_reg + 1'b1;
            end else begin
                level_next = level_dec;
                if (level_dec == '0) begin
                    hold_next = ffp_pkg::HOLD_W'(off_time);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            hold_reg  <= ffp_pkg::HOLD_RST[LANE_IDX];
            ramp_reg  <= 1'b0;
        end else begin
            level_reg <= level_next;
            hold_reg  <= hold_next;
            ramp_reg  <= ramp_next;
        end
    end

    assign level = level_reg;

endmodule

// ===== rtl/ffp_pwm.sv =====
module ffp_pwm #(
    parameter int LANES = ffp_pkg::NUM_LEDS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 tick_en,
    input  ffp_pkg::level_t [LANES-1:0]          levels,
    output logic [ffp_pkg::LANE_LIMIT-1:0]       mask
);

    localparam logic [ffp_pkg::LANE_LIMIT-1:0] LaneMask =
        ffp_pkg::LANE_LIMIT'((1 << LANES) - 1);

    ffp_pkg::level_t                    count_reg, count_next;
    ffp_pkg::level_t [LANES-1:0]        latched_reg, latched_next;
    logic [ffp_pkg::LANE_LIMIT-1:0]     mask_reg, mask_next;
    logic [ffp_pkg::LANE_LIMIT-1:0]     clr;
    logic                               wrap;

    assign wrap = (count_reg + 1'b1) == '0;

    always_comb begin
        count_next   = count_reg;
        latched_next = latched_reg;
        mask_next    = mask_reg;
        clr          = '0;
        if (tick_en) begin
            count_next = count_reg + 1'b1;
            if (wrap) begin
                latched_next = levels;
            end
            // Each lane compares its own latched level; the results merge into one mask.
            for (int n = 0; n < LANES; n++) begin
                clr[n] = (latched_next[n] == count_next);
            end
            mask_next = (wrap ? LaneMask : mask_reg) & ~clr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= ffp_pkg::PWM_COUNT_RST;
            latched_reg <= '0;
            mask_reg    <= LaneMask;
        end else begin
            count_reg   <= count_next;
            latched_reg <= latched_next;
            mask_reg    <= mask_next;
        end
    end

    assign mask = mask_reg;

endmodule

// ===== rtl/firefly_led_pulse_pwm.sv =====
// Firefly LED pulser with software-style PWM for up to five LEDs.
// Input channel (s_*): one item per tick. s_tuser is the command: PWM tick or
// state-update tick. s_tdata carries one random byte per LED, used only on
// update ticks. Output channel (m_*): exactly one item per input item, the
// LED drive mask as it stood before that input item was applied.
// Configuration channel (cfg_*): index 0 writes max_level, index 1 writes
// off_scale; other indexes are ignored. It is always ready.
// The result of an item is registered and valid in the cycle after the item
// is accepted. Throughput is one item per cycle while the receiver keeps up, set by
// the single output register; all LED lanes update side by side in that cycle.
// When the receiver stalls, the output register holds its item and s_tready
// drops until the item is taken, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) restores the registers to their defaults,
// turns all LEDs to level zero with staggered initial off times, sets the
// PWM counter so that the first PWM tick wraps it, and empties the output.
`include "assert_macros.svh"

module firefly_led_pulse_pwm #(
    parameter int NUM_LEDS = ffp_pkg::NUM_LEDS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,   // random_a, random_b, ..., random_e
    input  logic                              s_tuser,   // command
    // Result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // led_mask, then zero fill
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ffp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // There are only five random bytes and five mask bits.
    localparam int LANES = (NUM_LEDS < ffp_pkg::LANE_LIMIT) ? NUM_LEDS : ffp_pkg::LANE_LIMIT;
    localparam logic [ffp_pkg::LANE_LIMIT-1:0] LaneMask =
        ffp_pkg::LANE_LIMIT'((1 << LANES) - 1);

    ffp_pkg::level_t                   max_level_reg;
    logic [ffp_pkg::SCALE_W-1:0]       off_scale_reg;
    logic                              out_valid_reg;
    logic [ffp_pkg::LANE_LIMIT-1:0]    out_mask_reg;
    logic [ffp_pkg::LANE_LIMIT-1:0]    mask;
    ffp_pkg::level_t [LANES-1:0]       levels;
    logic                              accept;
    logic                              update_en;
    logic                              tick_en;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_level_reg <= ffp_pkg::MAX_LEVEL_RST;
            off_scale_reg <= ffp_pkg::OFF_SCALE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ffp_pkg::REG_MAX_LEVEL: begin
                    max_level_reg <= cfg_data[ffp_pkg::LEVEL_W-1:0];
                end
                ffp_pkg::REG_OFF_SCALE: begin
                    off_scale_reg <= cfg_data[ffp_pkg::SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // An item is taken whenever the output register is empty or being drained.
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign update_en = accept && (s_tuser == ffp_pkg::CMD_UPDATE);
    assign tick_en   = accept && (s_tuser == ffp_pkg::CMD_PWM_TICK);

    // One brightness state machine per LED.
    for (genvar n = 0; n < LANES; n++) begin : g_lane
        ffp_lane #(
            .LANE_IDX (n)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .update_en (update_en),
            .rnd       (s_tdata[n*ffp_pkg::RND_W +: ffp_pkg::RND_W]),
            .max_level (max_level_reg),
            .off_scale (off_scale_reg),
            .level     (levels[n])
        );
    end

    // PWM counter, level latch and mask merge.
    ffp_pwm #(
        .LANES (LANES)
    ) u_pwm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (tick_en),
        .levels  (levels),
        .mask    (mask)
    );

    // Output register: the mask before this item's effect.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_mask_reg <= mask;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - ffp_pkg::LANE_LIMIT){1'b0}}, out_mask_reg};

    `ASSERT_NEXT(a_result_follows_item, aclk, aresetn, accept, m_tvalid)
    `ASSERT_NEXT(a_result_is_old_mask, aclk, aresetn, accept,
                 m_tdata[ffp_pkg::LANE_LIMIT-1:0] == $past(mask))
    `ASSERT_NOW(a_no_phantom_lanes, aclk, aresetn, 1'b1, (mask & ~LaneMask) == '0)
    `ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

endmodule
